// ===== src/spimf_pkg.sv =====
// ----------------------------------------------------------------------------
// spimf_pkg
// shared types, register codes and fifo helpers for the spi master controller
// ----------------------------------------------------------------------------
package spimf_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [FILL_W-1:0] t_fill;

    // request types
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // register map
    localparam logic [3:0] REG_CTRL     = 4'd0;
    localparam logic [3:0] REG_STATUS   = 4'd1;
    localparam logic [3:0] REG_RX_LEVEL = 4'd2;
    localparam logic [3:0] REG_TX_LEVEL = 4'd3;
    localparam logic [3:0] REG_DATA     = 4'd4;
    localparam logic [3:0] REG_RSR      = 4'd5;
    localparam logic [3:0] REG_CSR      = 4'd6;
    localparam logic [3:0] REG_START    = 4'd7;
    localparam logic [3:0] REG_MRR      = 4'd8;
    localparam logic [3:0] REG_RX_CLEAR = 4'd9;
    localparam logic [3:0] REG_LENGTH   = 4'd10;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] reg_sel;
        logic [7:0] wdata;
        logic [7:0] slave_reply;
    } t_in_req;

    typedef struct packed {
        logic [7:0] rdata;
        logic       exchange_valid;
        logic [7:0] mosi_byte;
        logic       first_of_burst;
        logic       select_slave;
        logic       release_slave;
        logic       irq;
    } t_out_res;

    function automatic t_ptr next_ptr(input t_ptr p);
        return (p == t_ptr'(FIFO_DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    function automatic logic [7:0] level_sat(input t_fill f);
        logic [31:0] ext;
        ext = 32'(f);
        return (ext > 32'd255) ? 8'hFF : ext[7:0];
    endfunction

endpackage

// ===== src/spi_master_fifo_controller.sv =====
// ----------------------------------------------------------------------------
// spi_master_fifo_controller
// byte-wide spi master with transmit and receive fifos behind registers
// ----------------------------------------------------------------------------
// Takes one request (register read, register write or transfer tick) per
// clock and returns one result per request in the cycle after acceptance. All
// register, pointer and burst updates happen at the accepting edge; the
// fifo memories are read at that same edge into registered read ports that
// feed the result, so a new request can follow every cycle while the output
// is taken. The input is stalled only while a result waits and the output
// is not ready. Fifo contents are not cleared at reset; empty fifos read 0.
// ----------------------------------------------------------------------------
module spi_master_fifo_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  spimf_pkg::t_in_req   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output spimf_pkg::t_out_res  o_out
);

    logic [7:0] r_tx_mem [spimf_pkg::FIFO_DEPTH];
    logic [7:0] r_rx_mem [spimf_pkg::FIFO_DEPTH];
    logic [7:0] r_tx_q, r_rx_q;

    spimf_pkg::t_ptr  r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    spimf_pkg::t_ptr  r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    spimf_pkg::t_fill r_tx_fill, n_tx_fill, r_rx_fill, n_rx_fill;

    logic [7:0] r_ctrl, n_ctrl, r_length, n_length, r_rx_level, n_rx_level;
    logic [7:0] r_count, n_count;
    logic       r_burst, n_burst, r_first, n_first;

    spimf_pkg::t_out_res r_res, n_res;
    logic r_tx_pop, r_rx_pop, r_out_valid;
    logic in_fire, tx_we, tx_re, rx_we, rx_re;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_tx_head  = r_tx_head;
        n_tx_tail  = r_tx_tail;
        n_tx_fill  = r_tx_fill;
        n_rx_head  = r_rx_head;
        n_rx_tail  = r_rx_tail;
        n_rx_fill  = r_rx_fill;
        n_ctrl     = r_ctrl;
        n_length   = r_length;
        n_rx_level = r_rx_level;
        n_count    = r_count;
        n_burst    = r_burst;
        n_first    = r_first;
        n_res      = '0;
        tx_we      = 1'b0;
        tx_re      = 1'b0;
        rx_we      = 1'b0;
        rx_re      = 1'b0;
        if (in_fire) begin
            unique case (i_in.req_type)
                spimf_pkg::REQ_READ: begin
                    unique case (i_in.reg_sel)
                        spimf_pkg::REG_CTRL:     n_res.rdata = r_ctrl;
                        spimf_pkg::REG_RX_LEVEL: n_res.rdata = r_rx_level;
                        spimf_pkg::REG_DATA: begin
                            if (r_rx_fill != '0) begin
                                rx_re     = 1'b1;
                                n_rx_tail = spimf_pkg::next_ptr(r_rx_tail);
                                n_rx_fill = r_rx_fill - spimf_pkg::t_fill'(1);
                            end
                        end
                        default: n_res.rdata = 8'h00;
                    endcase
                end
                spimf_pkg::REQ_WRITE: begin
                    unique case (i_in.reg_sel)
                        spimf_pkg::REG_CTRL:   n_ctrl   = i_in.wdata;
                        spimf_pkg::REG_LENGTH: n_length = i_in.wdata;
                        spimf_pkg::REG_DATA: begin
                            if (r_tx_fill != spimf_pkg::t_fill'(spimf_pkg::FIFO_DEPTH)) begin
                                tx_we     = 1'b1;
                                n_tx_head = spimf_pkg::next_ptr(r_tx_head);
                                n_tx_fill = r_tx_fill + spimf_pkg::t_fill'(1);
                            end
                        end
                        spimf_pkg::REG_START: begin
                            if (i_in.wdata[0]) begin
                                n_res.select_slave = 1'b1;
                                n_first = 1'b1;
                                n_burst = 1'b1;
                                n_count = 8'h00;
                            end
                        end
                        spimf_pkg::REG_RX_CLEAR: begin
                            if (i_in.wdata[0]) begin
                                n_rx_head = '0;
                                n_rx_tail = '0;
                                n_rx_fill = '0;
                            end
                        end
                        default: n_ctrl = r_ctrl;
                    endcase
                end
                spimf_pkg::REQ_TICK: begin
                    if (r_burst) begin
                        n_res.exchange_valid = 1'b1;
                        if (r_tx_fill != '0) begin
                            tx_re     = 1'b1;
                            n_tx_tail = spimf_pkg::next_ptr(r_tx_tail);
                            n_tx_fill = r_tx_fill - spimf_pkg::t_fill'(1);
                        end
                        if (r_first) begin
                            n_res.first_of_burst = 1'b1;
                            n_first = 1'b0;
                        end
                        if (r_rx_fill != spimf_pkg::t_fill'(spimf_pkg::FIFO_DEPTH)) begin
                            rx_we     = 1'b1;
                            n_rx_head = spimf_pkg::next_ptr(r_rx_head);
                            n_rx_fill = r_rx_fill + spimf_pkg::t_fill'(1);
                        end
                        n_rx_level = spimf_pkg::level_sat(n_rx_fill);
                        n_count    = r_count + 8'd1;
                        if (n_count == r_length) begin
                            n_burst             = 1'b0;
                            n_res.release_slave = 1'b1;
                            n_res.irq           = 1'b1;
                        end
                    end
                end
                default: n_res = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_fill   <= '0;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_fill   <= '0;
            r_ctrl      <= 8'h00;
            r_length    <= 8'h00;
            r_rx_level  <= 8'h00;
            r_count     <= 8'h00;
            r_burst     <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tx_head  <= n_tx_head;
            r_tx_tail  <= n_tx_tail;
            r_tx_fill  <= n_tx_fill;
            r_rx_head  <= n_rx_head;
            r_rx_tail  <= n_rx_tail;
            r_rx_fill  <= n_rx_fill;
            r_ctrl     <= n_ctrl;
            r_length   <= n_length;
            r_rx_level <= n_rx_level;
            r_count    <= n_count;
            r_burst    <= n_burst;
            r_first    <= n_first;
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res    <= n_res;
            r_tx_pop <= tx_re;
            r_rx_pop <= rx_re;
        end
    end

    // fifo memories
    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[r_tx_head] <= i_in.wdata;
        end
        if (tx_re) begin
            r_tx_q <= r_tx_mem[r_tx_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[r_rx_head] <= i_in.slave_reply;
        end
        if (rx_re) begin
            r_rx_q <= r_rx_mem[r_rx_tail];
        end
    end

    always_comb begin
        o_out = r_res;
        if (r_rx_pop) begin
            o_out.rdata = r_rx_q;
        end
        if (r_tx_pop) begin
            o_out.mosi_byte = r_tx_q;
        end
    end

`ifndef SYNTHESIS
    a_release_on_exchange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.release_slave) |-> o_out.exchange_valid)
        else $error("release without exchange");

    a_first_on_exchange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.first_of_burst) |-> o_out.exchange_valid)
        else $error("first marker without exchange");

    a_start_opens_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.req_type == spimf_pkg::REQ_WRITE
         && i_in.reg_sel == spimf_pkg::REG_START && i_in.wdata[0])
        |=> (r_burst && r_first && o_out.select_slave))
        else $error("start request did not open a burst");

    a_tx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_tx_fill) <= spimf_pkg::FIFO_DEPTH)
        else $error("transmit fill beyond depth");

    a_rx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rx_fill) <= spimf_pkg::FIFO_DEPTH)
        else $error("receive fill beyond depth");
`endif

endmodule

// ===== sim/spimf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spimf_checker
// watches both channels of the spi master controller, predicts the response
// to every accepted request from its own register and fifo state, and
// compares each accepted response against the oldest prediction
// ----------------------------------------------------------------------------
module spimf_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  spimf_pkg::t_in_req  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  spimf_pkg::t_out_res i_out,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_exchanges,
    output int                  o_bursts
);

    logic [7:0]          tx_mem [spimf_pkg::FIFO_DEPTH];
    logic [7:0]          rx_mem [spimf_pkg::FIFO_DEPTH];
    spimf_pkg::t_ptr     tx_rd, tx_wr, rx_rd, rx_wr;
    spimf_pkg::t_fill    tx_cnt, rx_cnt;
    logic [7:0]          ctrl_q, len_q, rx_lvl_q, xfer_cnt;
    logic                burst_on, first_due;
    spimf_pkg::t_out_res expected_responses [$];
    int                  err_cnt, xchg_cnt, burst_cnt;

    function automatic spimf_pkg::t_ptr ptr_inc(input spimf_pkg::t_ptr p);
        return spimf_pkg::t_ptr'((int'(p) + 1) % spimf_pkg::FIFO_DEPTH);
    endfunction

    function automatic string fmt_res(input spimf_pkg::t_out_res r);
        return $sformatf("rdata=%02h xv=%0b mosi=%02h first=%0b sel=%0b rel=%0b irq=%0b",
                         r.rdata, r.exchange_valid, r.mosi_byte, r.first_of_burst,
                         r.select_slave, r.release_slave, r.irq);
    endfunction

    task automatic predict_spi_response(input spimf_pkg::t_in_req r,
                                        output spimf_pkg::t_out_res res);
        res = '0;
        case (r.req_type)
            spimf_pkg::REQ_READ: begin
                case (r.reg_sel)
                    spimf_pkg::REG_CTRL:     res.rdata = ctrl_q;
                    spimf_pkg::REG_RX_LEVEL: res.rdata = rx_lvl_q;
                    spimf_pkg::REG_DATA: if (rx_cnt != 0) begin
                        res.rdata = rx_mem[rx_rd];
                        rx_rd     = ptr_inc(rx_rd);
                        rx_cnt    = rx_cnt - 1'b1;
                    end
                    default: ;
                endcase
            end
            spimf_pkg::REQ_WRITE: begin
                case (r.reg_sel)
                    spimf_pkg::REG_CTRL: ctrl_q = r.wdata;
                    spimf_pkg::REG_DATA: if (tx_cnt < spimf_pkg::FIFO_DEPTH) begin
                        tx_mem[tx_wr] = r.wdata;
                        tx_wr         = ptr_inc(tx_wr);
                        tx_cnt        = tx_cnt + 1'b1;
                    end
                    spimf_pkg::REG_START: if (r.wdata[0]) begin
                        res.select_slave = 1'b1;
                        first_due        = 1'b1;
                        burst_on         = 1'b1;
                        xfer_cnt         = 8'd0;
                    end
                    spimf_pkg::REG_RX_CLEAR: if (r.wdata[0]) begin
                        rx_rd  = '0;
                        rx_wr  = '0;
                        rx_cnt = '0;
                    end
                    spimf_pkg::REG_LENGTH: len_q = r.wdata;
                    default: ;
                endcase
            end
            spimf_pkg::REQ_TICK: if (burst_on) begin
                res.exchange_valid = 1'b1;
                if (tx_cnt != 0) begin
                    res.mosi_byte = tx_mem[tx_rd];
                    tx_rd         = ptr_inc(tx_rd);
                    tx_cnt        = tx_cnt - 1'b1;
                end
                res.first_of_burst = first_due;
                first_due          = 1'b0;
                if (rx_cnt < spimf_pkg::FIFO_DEPTH) begin
                    rx_mem[rx_wr] = r.slave_reply;
                    rx_wr         = ptr_inc(rx_wr);
                    rx_cnt        = rx_cnt + 1'b1;
                end
                rx_lvl_q = (rx_cnt > 255) ? 8'hFF : rx_cnt[7:0];
                xfer_cnt = xfer_cnt + 8'd1;
                xchg_cnt++;
                if (xfer_cnt == len_q) begin
                    burst_on          = 1'b0;
                    res.release_slave = 1'b1;
                    res.irq           = 1'b1;
                    burst_cnt++;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        spimf_pkg::t_out_res want;
        if (!i_rst_n) begin
            tx_rd     = '0;
            tx_wr     = '0;
            tx_cnt    = '0;
            rx_rd     = '0;
            rx_wr     = '0;
            rx_cnt    = '0;
            ctrl_q    = 8'd0;
            len_q     = 8'd0;
            rx_lvl_q  = 8'd0;
            xfer_cnt  = 8'd0;
            burst_on  = 1'b0;
            first_due = 1'b0;
            expected_responses.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_responses.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: response with no request waiting: %s",
                                 $time, fmt_res(i_out));
                end else begin
                    want = expected_responses.pop_front();
                    if (i_out !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: response mismatch\n  expected %s\n  actual   %s",
                                     $time, fmt_res(want), fmt_res(i_out));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_spi_response(i_in, want);
                expected_responses.push_back(want);
            end
        end
        o_pending   <= expected_responses.size();
        o_errors    <= err_cnt;
        o_exchanges <= xchg_cnt;
        o_bursts    <= burst_cnt;
    end

endmodule

// ===== sim/spi_master_fifo_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_fifo_controller_tb
// drives register reads, writes and transfer ticks into the spi master
// controller in a directed opening, in random bursts mixed with noise under
// three sender and receiver idle profiles, and in a long burst that overflows
// the receive fifo and wraps the count; a checker beside the block predicts
// every response
// ----------------------------------------------------------------------------
module spi_master_fifo_controller_tb;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASE_ITEMS    = 45;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam logic [3:0] REG_UNMAPPED   = 4'd15;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    spimf_pkg::t_in_req  in_req    = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    spimf_pkg::t_out_res out_res;

    int snd_idle_pct = 17;
    int rcv_idle_pct = 71;
    int sent_items   = 0;
    int stall_cycles = 0;
    int chk_errors, chk_pending, chk_exchanges, chk_bursts;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    spi_master_fifo_controller uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res)
    );

    spimf_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_req),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_res),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_exchanges (chk_exchanges),
        .o_bursts    (chk_bursts)
    );

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request or response moved for %0d cycles",
                         stall_cycles);
                $display("spi_master_fifo_controller regression: fail");
                $finish;
            end
        end
    end

    function automatic spimf_pkg::t_in_req mk_req(input logic [1:0] kind,
                                                  input logic [3:0] sel,
                                                  input logic [7:0] wd,
                                                  input logic [7:0] reply);
        spimf_pkg::t_in_req r;
        r.req_type    = kind;
        r.reg_sel     = sel;
        r.wdata       = wd;
        r.slave_reply = reply;
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    task automatic send_request(input spimf_pkg::t_in_req r);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (!in_ready);
        sent_items++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
    endtask

    task automatic run_random_phase(input int n_items, input int s_pct, input int r_pct);
        int stop_at, blen;
        snd_idle_pct = s_pct;
        rcv_idle_pct = r_pct;
        stop_at      = sent_items + n_items;
        while (sent_items < stop_at) begin
            if ($urandom_range(99) < 75) begin
                blen = $urandom_range(1, 6);
                send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_LENGTH,
                                    8'(blen), rand_byte()));
                repeat ($urandom_range(0, blen + 2))
                    send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_DATA,
                                        rand_byte(), rand_byte()));
                send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_START,
                                    rand_byte() | 8'h01, rand_byte()));
                repeat (blen + $urandom_range(0, 2)) begin
                    if ($urandom_range(9) == 0)
                        send_request(mk_req(spimf_pkg::REQ_READ, spimf_pkg::REG_RX_LEVEL,
                                            rand_byte(), rand_byte()));
                    send_request(mk_req(spimf_pkg::REQ_TICK, 4'($urandom),
                                        rand_byte(), rand_byte()));
                end
                repeat ($urandom_range(0, blen + 2))
                    send_request(mk_req(spimf_pkg::REQ_READ, spimf_pkg::REG_DATA,
                                        rand_byte(), rand_byte()));
                if ($urandom_range(7) == 0)
                    send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_RX_CLEAR,
                                        rand_byte(), rand_byte()));
            end else begin
                send_request(mk_req(2'($urandom), 4'($urandom), rand_byte(), rand_byte()));
            end
        end
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed opening
        send_request(mk_req(spimf_pkg::REQ_READ,  spimf_pkg::REG_DATA,     8'hFF, 8'hFF));
        send_request(mk_req(spimf_pkg::REQ_TICK,  spimf_pkg::REG_DATA,     8'hFF, 8'hFF));
        send_request(mk_req(REQ_UNUSED,           spimf_pkg::REG_DATA,     8'hFF, 8'hFF));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_CTRL,     8'hFF, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_READ,  spimf_pkg::REG_CTRL,     8'h00, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_CTRL,     8'h00, 8'hFF));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_STATUS,   8'hFF, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_READ,  spimf_pkg::REG_STATUS,   8'h00, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_READ,  spimf_pkg::REG_TX_LEVEL, 8'h00, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_RSR,      8'hFF, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_CSR,      8'hFF, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_MRR,      8'hFF, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_READ,  spimf_pkg::REG_RSR,      8'h00, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_START,    8'hFE, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_RX_CLEAR, 8'hFE, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_LENGTH,   8'd2,  8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_DATA,     8'h00, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_DATA,     8'hFF, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_START,    8'h01, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_TICK,  spimf_pkg::REG_CTRL,     8'h00, 8'hFF));
        send_request(mk_req(spimf_pkg::REQ_TICK,  spimf_pkg::REG_CTRL,     8'h00, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_READ,  spimf_pkg::REG_RX_LEVEL, 8'h00, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_START,    8'hFF, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_TICK,  spimf_pkg::REG_CTRL,     8'h00, 8'hA5));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_START,    8'h01, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_TICK,  spimf_pkg::REG_CTRL,     8'h00, 8'h5A));
        send_request(mk_req(spimf_pkg::REQ_TICK,  spimf_pkg::REG_CTRL,     8'h00, 8'h3C));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_RX_CLEAR, 8'h01, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_READ,  spimf_pkg::REG_DATA,     8'h00, 8'h00));
        send_request(mk_req(spimf_pkg::REQ_WRITE, REG_UNMAPPED,            8'hFF, 8'hFF));
        send_request(mk_req(spimf_pkg::REQ_READ,  REG_UNMAPPED,            8'hFF, 8'hFF));
        drain_results();

        run_random_phase(PHASE_ITEMS, 17, 71);
        drain_results();
        run_random_phase(PHASE_ITEMS, 71, 17);
        drain_results();
        run_random_phase(PHASE_ITEMS, 0, 0);

        // overflow the receive fifo in one burst whose length is cut below the running count
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_RX_CLEAR, 8'h01, rand_byte()));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_LENGTH, 8'h00, rand_byte()));
        repeat (3)
            send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_DATA,
                                rand_byte(), rand_byte()));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_START, 8'h01, rand_byte()));
        repeat (250)
            send_request(mk_req(spimf_pkg::REQ_TICK, spimf_pkg::REG_CTRL,
                                rand_byte(), rand_byte()));
        send_request(mk_req(spimf_pkg::REQ_WRITE, spimf_pkg::REG_LENGTH, 8'd5, rand_byte()));
        repeat (12)
            send_request(mk_req(spimf_pkg::REQ_TICK, spimf_pkg::REG_CTRL,
                                rand_byte(), rand_byte()));
        send_request(mk_req(spimf_pkg::REQ_READ, spimf_pkg::REG_RX_LEVEL,
                            rand_byte(), rand_byte()));
        repeat (4)
            send_request(mk_req(spimf_pkg::REQ_READ, spimf_pkg::REG_DATA,
                                rand_byte(), rand_byte()));
        drain_results();
        repeat (4) @(negedge clk);

        $display("covered %0d requests over three idle profiles: %0d byte exchanges, %0d bursts",
                 sent_items, chk_exchanges, chk_bursts);
        $display("including empty fifos, a receive fifo overflow with level saturation and count wrap");
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("spi_master_fifo_controller regression: pass");
        end else begin
            $display("%0d mismatches, %0d responses missing", chk_errors, chk_pending);
            $display("spi_master_fifo_controller regression: fail");
        end
        $finish;
    end

endmodule
